[hw/rtl/tpet_pkg.sv]
package tpet_pkg;

	// Controller status byte layout
	localparam int unsigned STATUS_WIDTH = 8;
	localparam int unsigned READY_BIT    = 7;
	localparam int unsigned COUNT_WIDTH  = 4;

	// Register widths and reset values
	localparam int unsigned DELAY_WIDTH  = 16;
	localparam int unsigned THRESH_WIDTH = 8;
	localparam logic [DELAY_WIDTH-1:0]  DELAY_RESET      = 16'd20;
	localparam logic [THRESH_WIDTH-1:0] THRESH_RESET     = 8'd20;
	localparam logic [COUNT_WIDTH-1:0]  MAX_POINTS_RESET = 4'd5;

	// Error counter saturates at its full range
	localparam logic [THRESH_WIDTH-1:0] FAIL_MAX = 8'hff;

	// Configuration port
	localparam int unsigned APB_DATA_WIDTH = 32;
	localparam int unsigned APB_ADDR_WIDTH = 4;

	typedef enum logic [1:0] {
		REG_RELEASE_DELAY = 2'd0,
		REG_REINIT_THRESH = 2'd1,
		REG_MAX_POINTS    = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_index_t;

	// Request kind carried on the input tuser bit
	typedef enum logic {
		CMD_POLL = 1'b0,
		CMD_READ = 1'b1
	} command_t;

endpackage

[hw/rtl/touch_poll_event_tracker.sv]
// Touch poll event tracker. Each input request is either a touch-controller poll
// result (s_tuser = 0) or a consumer read of the pending event (s_tuser = 1), and
// every request yields exactly one result. The block takes one request per clock
// cycle unless output back-pressure stalls it. An accepted request waits in the
// input register until the result register can take it, and its result is
// presented on m_tvalid/m_tdata from the next clock edge onward. All state
// updates for a request are done in the cycle in which it moves from the input
// register to the result register. Both stages hold under back-pressure, so
// s_tready drops only while both are full and m_tready is low. Configuration
// registers sit on an APB-style port at byte addresses 0 (release delay, ms),
// 4 (reinit threshold) and 8 (max point count). Write them only while no request
// is in flight.
module touch_poll_event_tracker
	import tpet_pkg::*;
#(
	parameter int unsigned TIME_WIDTH  = 32,
	parameter int unsigned COORD_WIDTH = 16,
	localparam int unsigned IN_BITS    = 1 + STATUS_WIDTH + 2*COORD_WIDTH + TIME_WIDTH,
	localparam int unsigned IN_WIDTH   = ((IN_BITS + 7) / 8) * 8,
	localparam int unsigned OUT_BITS   = 2 + 2*COORD_WIDTH + 4,
	localparam int unsigned OUT_WIDTH  = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,

	// Request stream
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// bus_error, status[7:0], point_x, point_y, now_ms, zero fill
	input  logic [IN_WIDTH-1:0]       s_tdata,
	// command
	input  logic                      s_tuser,

	// Result stream
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// read_status, out_down, out_x, out_y, event_pending, wakeup,
	// reinit_request, fast_poll, zero fill
	output logic [OUT_WIDTH-1:0]      m_tdata,

	// Configuration
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_ADDR_WIDTH-1:0] paddr,
	input  logic [APB_DATA_WIDTH-1:0] pwdata,
	output logic [APB_DATA_WIDTH-1:0] prdata,
	output logic                      pready
);

	// Input field offsets
	localparam int unsigned ST_LO = 1;
	localparam int unsigned X_LO  = ST_LO + STATUS_WIDTH;
	localparam int unsigned Y_LO  = X_LO + COORD_WIDTH;
	localparam int unsigned T_LO  = Y_LO + COORD_WIDTH;

	// Configuration registers
	logic [DELAY_WIDTH-1:0]  delay_q;
	logic [THRESH_WIDTH-1:0] thresh_q;
	logic [COUNT_WIDTH-1:0]  max_pts_q;
	reg_index_t              reg_idx;
	logic                    cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_index_t'(paddr[3:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	// Write the addressed register; ignore the unused slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q   <= DELAY_RESET;
			thresh_q  <= THRESH_RESET;
			max_pts_q <= MAX_POINTS_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_RELEASE_DELAY: delay_q   <= pwdata[DELAY_WIDTH-1:0];
				REG_REINIT_THRESH: thresh_q  <= pwdata[THRESH_WIDTH-1:0];
				REG_MAX_POINTS:    max_pts_q <= pwdata[COUNT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (reg_idx)
			REG_RELEASE_DELAY: prdata = APB_DATA_WIDTH'(delay_q);
			REG_REINIT_THRESH: prdata = APB_DATA_WIDTH'(thresh_q);
			REG_MAX_POINTS:    prdata = APB_DATA_WIDTH'(max_pts_q);
			default:           prdata = '0;
		endcase
	end

	// Input register stage
	logic                    valid_s1;
	command_t                cmd_s1;
	logic                    err_s1;
	logic [STATUS_WIDTH-1:0] status_s1;
	logic [COORD_WIDTH-1:0]  px_s1;
	logic [COORD_WIDTH-1:0]  py_s1;
	logic [TIME_WIDTH-1:0]   now_s1;
	logic                    advance;

	assign advance  = valid_s1 & (~m_tvalid | m_tready);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1    <= command_t'(s_tuser);
			err_s1    <= s_tdata[0];
			status_s1 <= s_tdata[ST_LO +: STATUS_WIDTH];
			px_s1     <= s_tdata[X_LO +: COORD_WIDTH];
			py_s1     <= s_tdata[Y_LO +: COORD_WIDTH];
			now_s1    <= s_tdata[T_LO +: TIME_WIDTH];
		end
	end

	// Tracker state
	logic                    touch_down_q;
	logic [COORD_WIDTH-1:0]  held_x_q;
	logic [COORD_WIDTH-1:0]  held_y_q;
	logic [TIME_WIDTH-1:0]   last_time_q;
	logic [THRESH_WIDTH-1:0] fail_cnt_q;
	logic                    pend_q;
	logic                    pend_down_q;
	logic [COORD_WIDTH-1:0]  pend_x_q;
	logic [COORD_WIDTH-1:0]  pend_y_q;

	// Next-state and result logic
	logic [COUNT_WIDTH-1:0]  count;
	logic                    press;
	logic                    release_ev;
	logic [TIME_WIDTH-1:0]   elapsed;
	logic [THRESH_WIDTH-1:0] fail_inc;
	logic                    touch_down_d;
	logic [THRESH_WIDTH-1:0] fail_cnt_d;
	logic                    pend_d;
	logic                    pend_down_d;
	logic [COORD_WIDTH-1:0]  pend_x_d;
	logic [COORD_WIDTH-1:0]  pend_y_d;
	logic                    rd_status;
	logic                    rd_down;
	logic [COORD_WIDTH-1:0]  rd_x;
	logic [COORD_WIDTH-1:0]  rd_y;
	logic                    wake;
	logic                    reinit;

	always_comb begin
		count        = '0;
		press        = 1'b0;
		release_ev   = 1'b0;
		elapsed      = now_s1 - last_time_q;
		fail_inc     = (fail_cnt_q < FAIL_MAX) ? fail_cnt_q + 1'b1 : fail_cnt_q;
		touch_down_d = touch_down_q;
		fail_cnt_d   = fail_cnt_q;
		pend_d       = pend_q;
		pend_down_d  = pend_down_q;
		pend_x_d     = pend_x_q;
		pend_y_d     = pend_y_q;
		rd_status    = 1'b0;
		rd_down      = 1'b0;
		rd_x         = '0;
		rd_y         = '0;
		wake         = 1'b0;
		reinit       = 1'b0;

		unique case (cmd_s1)
			CMD_READ: begin
				// Hand over the pending event and drop it
				if (pend_q) begin
					rd_status = 1'b1;
					rd_down   = pend_down_q;
					rd_x      = pend_x_q;
					rd_y      = pend_y_q;
					pend_d    = 1'b0;
				end
			end
			CMD_POLL: begin
				// Decode point count; out-of-range counts mean no touch
				if (status_s1[READY_BIT] &&
				    status_s1[COUNT_WIDTH-1:0] <= max_pts_q) begin
					count = status_s1[COUNT_WIDTH-1:0];
				end
				press      = ~err_s1 & (count != '0);
				release_ev = (err_s1 | (count == '0)) & touch_down_q &
				             (elapsed > TIME_WIDTH'(delay_q));

				if (press) begin
					touch_down_d = 1'b1;
					pend_down_d  = 1'b1;
					pend_x_d     = px_s1;
					pend_y_d     = py_s1;
				end else if (release_ev) begin
					touch_down_d = 1'b0;
					pend_down_d  = 1'b0;
					pend_x_d     = held_x_q;
					pend_y_d     = held_y_q;
				end
				pend_d = pend_q | press | release_ev;
				wake   = ~pend_q & (press | release_ev);

				// Count consecutive bus errors, request reinit at threshold
				if (!err_s1) begin
					fail_cnt_d = '0;
				end else if (fail_inc >= thresh_q) begin
					fail_cnt_d = '0;
					reinit     = 1'b1;
				end else begin
					fail_cnt_d = fail_inc;
				end
			end
			default: ;
		endcase
	end

	// Advance state with the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_down_q <= 1'b0;
			held_x_q     <= '0;
			held_y_q     <= '0;
			last_time_q  <= '0;
			fail_cnt_q   <= '0;
			pend_q       <= 1'b0;
			pend_down_q  <= 1'b0;
			pend_x_q     <= '0;
			pend_y_q     <= '0;
		end else if (advance) begin
			touch_down_q <= touch_down_d;
			fail_cnt_q   <= fail_cnt_d;
			pend_q       <= pend_d;
			pend_down_q  <= pend_down_d;
			pend_x_q     <= pend_x_d;
			pend_y_q     <= pend_y_d;
			if (press) begin
				held_x_q    <= px_s1;
				held_y_q    <= py_s1;
				last_time_q <= now_s1;
			end
		end
	end

	// Result register
	logic                   out_valid_q;
	logic                   out_rs_q;
	logic                   out_down_q;
	logic [COORD_WIDTH-1:0] out_x_q;
	logic [COORD_WIDTH-1:0] out_y_q;
	logic                   out_pend_q;
	logic                   out_wake_q;
	logic                   out_reinit_q;
	logic                   out_fast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_rs_q     <= rd_status;
			out_down_q   <= rd_down;
			out_x_q      <= rd_x;
			out_y_q      <= rd_y;
			out_pend_q   <= pend_d;
			out_wake_q   <= wake;
			out_reinit_q <= reinit;
			out_fast_q   <= touch_down_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_WIDTH'({out_fast_q, out_reinit_q, out_wake_q, out_pend_q,
	                             out_y_q, out_x_q, out_down_q, out_rs_q});

	// Input stage stalls only behind a full, blocked result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_tvalid && !m_tready))
		else $error("input stalled without output back-pressure");

	// A shown result reflects the state it left behind
	a_state_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_fast_q == touch_down_q && out_pend_q == pend_q))
		else $error("result flags disagree with tracker state");

	// Reinit request leaves the error count cleared
	a_reinit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_reinit_q) |-> (fail_cnt_q == '0))
		else $error("error count not cleared after reinit request");

	// Wakeup implies an event is now pending and no read was served
	a_wake_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_wake_q) |-> (out_pend_q && !out_rs_q))
		else $error("wakeup without pending event");

	// A pending event cannot appear on a read
	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cmd_s1 == CMD_READ) |=> !pend_q)
		else $error("read left an event pending");

endmodule

[test/touch_poll_event_tracker_tb.sv]
module touch_poll_event_tracker_tb;
	import tpet_pkg::*;

	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned MAX_REPORTS = 40;
	localparam int unsigned HOLD_AFTER = 400;
	localparam int unsigned HOLD_CYCLES = 150;

	typedef struct {
		command_t    cmd;
		logic        bus_error;
		logic [7:0]  status;
		logic [15:0] x;
		logic [15:0] y;
		logic [31:0] now_ms;
	} request_t;

	typedef struct {
		logic        read_status;
		logic        down;
		logic [15:0] x;
		logic [15:0] y;
		logic        pending;
		logic        wakeup;
		logic        reinit;
		logic        fast_poll;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// bus_error, status[7:0], point_x, point_y, now_ms, zero fill
	logic [79:0] s_tdata = '0;
	// command
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// read_status, out_down, out_x, out_y, event_pending, wakeup,
	// reinit_request, fast_poll, zero fill
	logic [39:0] m_tdata;

	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [APB_ADDR_WIDTH-1:0] paddr = '0;
	logic [APB_DATA_WIDTH-1:0] pwdata = '0;
	logic [APB_DATA_WIDTH-1:0] prdata;
	logic                      pready;

	touch_poll_event_tracker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	// Predicted block state and register copies
	logic [15:0] cfg_delay;
	logic [7:0]  cfg_threshold;
	logic [3:0]  cfg_max_points;
	logic        track_down;
	logic [15:0] held_x;
	logic [15:0] held_y;
	logic [31:0] touch_ms;
	logic [7:0]  err_streak;
	logic        evt_valid;
	logic        evt_down;
	logic [15:0] evt_x;
	logic [15:0] evt_y;

	request_t    pending_requests[$];
	result_t     expected_results[$];
	request_t    in_flight;

	logic [31:0] clock_ms;
	int unsigned items_planned = 0;
	int unsigned requests_accepted = 0;
	int unsigned results_checked = 0;
	int unsigned mismatches = 0;
	int unsigned settings_used = 0;
	int unsigned presses_seen = 0;
	int unsigned releases_seen = 0;
	int unsigned reinits_seen = 0;
	bit          gaps_on = 1'b1;
	bit          stalls_on = 1'b1;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	int unsigned quiet_cycles = 0;

	function automatic int unsigned draw_gap(bit enabled);
		int unsigned pick;
		if (!enabled)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 65)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Overwrite the single event slot; report whether it was empty
	function automatic logic post_event(logic down, logic [15:0] x, logic [15:0] y);
		logic woke;
		woke = !evt_valid;
		evt_valid = 1'b1;
		evt_down = down;
		evt_x = x;
		evt_y = y;
		return woke;
	endfunction

	function automatic result_t track_touch(request_t r);
		result_t     res;
		logic [3:0]  count;
		logic [31:0] elapsed;
		res = '{default: '0};
		if (r.cmd == CMD_READ) begin
			if (evt_valid) begin
				res.read_status = 1'b1;
				res.down = evt_down;
				res.x = evt_x;
				res.y = evt_y;
				evt_valid = 1'b0;
			end
		end else begin
			count = r.status[READY_BIT] ? r.status[3:0] : 4'd0;
			if (count > cfg_max_points)
				count = 4'd0;
			if (!r.bus_error && count != 0) begin
				err_streak = '0;
				held_x = r.x;
				held_y = r.y;
				touch_ms = r.now_ms;
				track_down = 1'b1;
				if (post_event(1'b1, r.x, r.y))
					res.wakeup = 1'b1;
			end else if (!r.bus_error) begin
				err_streak = '0;
			end
			// Release after the delay, on an empty poll or a failed one
			elapsed = r.now_ms - touch_ms;
			if ((r.bus_error || count == 0) && track_down && elapsed > {16'd0, cfg_delay}) begin
				track_down = 1'b0;
				if (post_event(1'b0, held_x, held_y))
					res.wakeup = 1'b1;
			end
			if (r.bus_error) begin
				if (err_streak != FAIL_MAX)
					err_streak++;
				if (err_streak >= cfg_threshold) begin
					err_streak = '0;
					res.reinit = 1'b1;
				end
			end
		end
		res.pending = evt_valid;
		res.fast_poll = track_down;
		return res;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		end
	endtask

	// Offer queued requests, with random gaps between them
	always @(posedge clk) begin : drive_requests
		logic offer;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left = 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				expected_results.push_back(track_touch(in_flight));
				requests_accepted++;
			end
			offer = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_requests.size() > 0) begin
				in_flight = pending_requests.pop_front();
				s_tdata <= {7'd0, in_flight.now_ms, in_flight.y, in_flight.x,
					in_flight.status, in_flight.bus_error};
				s_tuser <= in_flight.cmd;
				offer = 1'b1;
				gap_left = draw_gap(gaps_on);
			end
			s_tvalid <= offer;
		end
	end

	// Check results against the oldest prediction and drive back-pressure
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_checked++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result with no request outstanding, expected none got %h",
						$time, m_tdata);
			end else begin
				want = expected_results.pop_front();
				if (want.read_status && want.down)
					presses_seen++;
				else if (want.read_status)
					releases_seen++;
				if (want.reinit)
					reinits_seen++;
				check_field("read_status", 32'(want.read_status), 32'(m_tdata[0]));
				check_field("out_down", 32'(want.down), 32'(m_tdata[1]));
				check_field("out_x", 32'(want.x), 32'(m_tdata[17:2]));
				check_field("out_y", 32'(want.y), 32'(m_tdata[33:18]));
				check_field("event_pending", 32'(want.pending), 32'(m_tdata[34]));
				check_field("wakeup", 32'(want.wakeup), 32'(m_tdata[35]));
				check_field("reinit_request", 32'(want.reinit), 32'(m_tdata[36]));
				check_field("fast_poll", 32'(want.fast_poll), 32'(m_tdata[37]));
			end
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			// Hold off once for a long stretch so the block fills and stalls
			if (!hold_done && results_checked >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				stall_left = draw_gap(stalls_on);
				m_tready <= (stall_left == 0);
			end
		end
	end

	// End the run if nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic add_request(command_t cmd, logic err, logic [7:0] st,
			logic [15:0] x, logic [15:0] y, logic [31:0] t);
		request_t r;
		r.cmd = cmd;
		r.bus_error = err;
		r.status = st;
		r.x = x;
		r.y = y;
		r.now_ms = t;
		pending_requests.push_back(r);
		items_planned++;
	endtask

	task automatic add_read();
		add_request(CMD_READ, 1'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
			$urandom);
	endtask

	task automatic add_poll(logic err, logic [7:0] st, logic [31:0] t);
		add_request(CMD_POLL, err, st, 16'($urandom), 16'($urandom), t);
	endtask

	function automatic logic [7:0] touch_status();
		logic [3:0] count;
		if (cfg_max_points == 0)
			count = 4'($urandom_range(1, 15));
		else
			count = 4'($urandom_range(1, cfg_max_points));
		return {1'b1, 3'($urandom), count};
	endfunction

	function automatic logic [7:0] idle_status();
		case ($urandom_range(0, 2))
			0: return {1'b0, 7'($urandom)};
			1: return {1'b1, 3'($urandom), 4'd0};
			default: begin
				if (cfg_max_points == 4'd15)
					return {1'b1, 3'($urandom), 4'd0};
				return {1'b1, 3'($urandom), 4'($urandom_range(cfg_max_points + 1, 15))};
			end
		endcase
	endfunction

	// Press, hold and release with random content and timing
	task automatic touch_session();
		logic [31:0] press_ms;
		repeat ($urandom_range(1, 6)) begin
			clock_ms += $urandom_range(0, 5);
			press_ms = clock_ms;
			add_poll(1'b0, touch_status(), clock_ms);
			if ($urandom_range(0, 2) == 0)
				add_read();
		end
		if ($urandom_range(0, 2) == 0) begin
			clock_ms += $urandom_range(0, cfg_delay);
			add_poll(1'b0, idle_status(), clock_ms);
		end
		if ($urandom_range(0, 4) == 0) begin
			// Exactly at the delay nothing happens; one more ms releases
			add_poll(1'b0, idle_status(), press_ms + cfg_delay);
			clock_ms = press_ms + cfg_delay + 1;
		end else begin
			clock_ms += cfg_delay + 1 + $urandom_range(0, 3);
		end
		add_poll($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0 ? touch_status() :
			idle_status(), clock_ms);
		if ($urandom_range(0, 4) < 3)
			add_read();
	endtask

	task automatic error_burst();
		int unsigned len;
		if (cfg_threshold > 40 && $urandom_range(0, 19) == 0)
			len = cfg_threshold + 1;
		else
			len = $urandom_range(1, (cfg_threshold < 40 ? cfg_threshold : 40) + 2);
		repeat (len) begin
			clock_ms += $urandom_range(0, 50);
			add_poll(1'b1, 8'($urandom), clock_ms);
			if ($urandom_range(0, 9) == 0)
				add_read();
		end
	endtask

	task automatic run_random(int unsigned count);
		int unsigned stop_at;
		int unsigned pick;
		stop_at = items_planned + count;
		while (items_planned < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				touch_session();
			else if (pick < 70)
				error_burst();
			else if (pick < 85)
				repeat ($urandom_range(1, 3)) add_read();
			else
				add_request(command_t'($urandom_range(0, 1)), 1'($urandom), 8'($urandom),
					16'($urandom), 16'($urandom),
					$urandom_range(0, 1) ? $urandom : clock_ms + $urandom_range(0, 100));
		end
	endtask

	task automatic wait_idle();
		while (pending_requests.size() != 0 || expected_results.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(reg_index_t idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_RELEASE_DELAY: cfg_delay = value[15:0];
			REG_REINIT_THRESH: cfg_threshold = value[7:0];
			REG_MAX_POINTS:    cfg_max_points = value[3:0];
			default: ;
		endcase
	endtask

	// Write all registers while idle; upper bits carry noise
	task automatic configure(logic [15:0] delay, logic [7:0] thresh, logic [3:0] maxp);
		wait_idle();
		apb_write(REG_RELEASE_DELAY, {16'($urandom), delay});
		apb_write(REG_REINIT_THRESH, {24'($urandom), thresh});
		apb_write(REG_MAX_POINTS, {28'($urandom), maxp});
		settings_used++;
	endtask

	initial begin
		cfg_delay = DELAY_RESET;
		cfg_threshold = THRESH_RESET;
		cfg_max_points = MAX_POINTS_RESET;
		track_down = 1'b0;
		held_x = '0;
		held_y = '0;
		touch_ms = '0;
		err_streak = '0;
		evt_valid = 1'b0;
		evt_down = 1'b0;
		evt_x = '0;
		evt_y = '0;
		settings_used = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty read, ready and count decode, overwrite, release timing
		add_read();
		add_request(CMD_POLL, 1'b0, 8'h00, 16'hffff, 16'hffff, 32'd1000);
		add_request(CMD_POLL, 1'b0, 8'h80, 16'h1234, 16'h5678, 32'd1000);
		add_request(CMD_POLL, 1'b0, 8'h81, 16'hffff, 16'h0000, 32'd1001);
		add_request(CMD_POLL, 1'b0, 8'h85, 16'h0000, 16'hffff, 32'd1002);
		add_read();
		add_read();
		add_request(CMD_POLL, 1'b0, 8'h86, 16'h1111, 16'h2222, 32'd1022);
		add_request(CMD_POLL, 1'b0, 8'h06, 16'h3333, 16'h4444, 32'd1023);
		add_read();
		add_request(CMD_POLL, 1'b1, 8'h83, 16'h5555, 16'haaaa, 32'd1030);
		add_request(CMD_POLL, 1'b0, 8'h7f, 16'h0f0f, 16'hf0f0, 32'd1031);
		add_request(CMD_POLL, 1'b0, 8'h8f, 16'h00ff, 16'hff00, 32'd1032);
		add_request(CMD_POLL, 1'b0, 8'hf3, 16'haaaa, 16'h5555, 32'd5000);
		add_request(CMD_POLL, 1'b1, 8'hff, 16'h0001, 16'h8000, 32'd5021);
		add_read();
		add_request(CMD_POLL, 1'b0, 8'hc2, 16'h8000, 16'h0001, 32'hffff_fff0);
		add_request(CMD_POLL, 1'b0, 8'h80, 16'h7fff, 16'hfffe, 32'h0000_0010);
		add_read();
		add_request(CMD_READ, 1'b1, 8'hff, 16'hffff, 16'hffff, 32'hffff_ffff);
		wait_idle();
		clock_ms = 32'd6000;

		run_random(250);

		configure(16'd0, 8'd1, 4'd15);
		run_random(280);

		// Long delay and counter limit, with time wrapping mid-phase
		configure(16'hffff, 8'hff, 4'd1);
		stalls_on = 1'b0;
		clock_ms = 32'hfff0_0000;
		run_random(280);

		// Zero threshold and zero point limit, no sender gaps
		configure(16'd0, 8'd0, 4'd0);
		wait_idle();
		apb_write(REG_UNUSED, $urandom);
		gaps_on = 1'b0;
		stalls_on = 1'b1;
		run_random(280);

		configure(16'd3, 8'd4, 4'd8);
		gaps_on = 1'b1;
		run_random(280);

		configure(16'($urandom_range(0, 200)), 8'($urandom_range(1, 30)),
			4'($urandom_range(1, 15)));
		run_random(280);

		// Back to reset values, both sides at full rate
		configure(DELAY_RESET, THRESH_RESET, MAX_POINTS_RESET);
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		run_random(250);

		wait_idle();
		repeat (8) @(posedge clk);
		$display("Checked %0d results from %0d requests across %0d register settings",
			results_checked, requests_accepted, settings_used);
		$display("Delivered %0d presses, %0d releases; %0d reinit requests seen",
			presses_seen, releases_seen, reinits_seen);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/tpet_pkg.sv
hw/rtl/touch_poll_event_tracker.sv
test/touch_poll_event_tracker_tb.sv
